/* src/fw2d_pkg.sv */
// Shared types, constants and the control program of the 2-D Fenwick tree rectangle-sum unit.
package fw2d_pkg;

    localparam int IDX_W  = 7;
    localparam int WALK_W = IDX_W + 1;
    localparam int IDX_MAX = (1 << IDX_W) - 1;
    localparam int SUM_W  = 64;
    localparam int DELTA_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_USED = 2'd1;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [3:0] t_step;

    localparam t_step S_CLR     = 4'd0;
    localparam t_step S_IDLE    = 4'd1;
    localparam t_step S_ADD_ROW = 4'd2;
    localparam t_step S_ADD_RD  = 4'd3;
    localparam t_step S_ADD_WR  = 4'd4;
    localparam t_step S_ADD_NXT = 4'd5;
    localparam t_step S_Q_TERM  = 4'd6;
    localparam t_step S_Q_ROW   = 4'd7;
    localparam t_step S_Q_RD    = 4'd8;
    localparam t_step S_Q_ACC   = 4'd9;
    localparam t_step S_Q_RNXT  = 4'd10;
    localparam t_step S_Q_NEXT  = 4'd11;
    localparam t_step S_OUT     = 4'd12;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_LOAD,
        IDX_UP,
        IDX_DOWN
    } t_idx_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_START,
        COND_EMIT,
        COND_I_END,
        COND_J_END,
        COND_K_MORE,
        COND_CLR_MORE
    } t_cond;

    typedef struct packed {
        t_cond   cond;
        t_step   target;
        t_idx_op i_op;
        t_idx_op j_op;
        logic    mem_rd;
        logic    mem_wr;
        logic    mem_clr;
        logic    acc_en;
        logic    k_inc;
        logic    idle;
        logic    emit;
    } t_ctrl;

    typedef struct packed {
        logic  start;
        t_step start_step;
        logic  i_end;
        logic  j_end;
        logic  k_more;
        logic  clr_more;
        logic  out_free;
    } t_flags;

    function automatic t_ctrl ctrl_rom(input t_step s);
        t_ctrl cw;
        cw = '0;
        case (s)
            S_CLR: begin
                cw.mem_clr = 1'b1;
                cw.cond    = COND_CLR_MORE;
                cw.target  = S_CLR;
            end
            S_IDLE: begin
                cw.idle   = 1'b1;
                cw.cond   = COND_START;
                cw.target = S_IDLE;
            end
            S_ADD_ROW: begin
                cw.j_op   = IDX_LOAD;
                cw.cond   = COND_I_END;
                cw.target = S_OUT;
            end
            S_ADD_RD: begin
                cw.mem_rd = 1'b1;
                cw.cond   = COND_J_END;
                cw.target = S_ADD_NXT;
            end
            S_ADD_WR: begin
                cw.mem_wr = 1'b1;
                cw.j_op   = IDX_UP;
                cw.cond   = COND_JUMP;
                cw.target = S_ADD_RD;
            end
            S_ADD_NXT: begin
                cw.i_op   = IDX_UP;
                cw.cond   = COND_JUMP;
                cw.target = S_ADD_ROW;
            end
            S_Q_TERM: begin
                cw.i_op = IDX_LOAD;
                cw.cond = COND_NEXT;
            end
            S_Q_ROW: begin
                cw.j_op   = IDX_LOAD;
                cw.cond   = COND_I_END;
                cw.target = S_Q_NEXT;
            end
            S_Q_RD: begin
                cw.mem_rd = 1'b1;
                cw.cond   = COND_J_END;
                cw.target = S_Q_RNXT;
            end
            S_Q_ACC: begin
                cw.acc_en = 1'b1;
                cw.j_op   = IDX_DOWN;
                cw.cond   = COND_JUMP;
                cw.target = S_Q_RD;
            end
            S_Q_RNXT: begin
                cw.i_op   = IDX_DOWN;
                cw.cond   = COND_JUMP;
                cw.target = S_Q_ROW;
            end
            S_Q_NEXT: begin
                cw.k_inc  = 1'b1;
                cw.cond   = COND_K_MORE;
                cw.target = S_Q_TERM;
            end
            S_OUT: begin
                cw.emit   = 1'b1;
                cw.cond   = COND_EMIT;
                cw.target = S_IDLE;
            end
            default: begin
                cw.cond   = COND_JUMP;
                cw.target = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

/* src/fenwick_tree_2d_rect_sum_unit.sv */
// Top level of the 2-D Fenwick tree rectangle-sum unit with its node memory and datapath.
// An add walks the row chain and, for each row node, the column chain, reading and updating each node.
// A query sums four prefix terms, each walking the row chain and, for each row, the column chain.
// One item is in work at a time; a finished result waits in the output register meanwhile.
// Reset is synchronous; afterwards a clearing pass over all MAX_ROWS * 2**ceil(log2(MAX_COLS))
// node memory words zeroes them before the first item is accepted.
module fenwick_tree_2d_rect_sum_unit
    import fw2d_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [IDX_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // row[6:0], col[13:7], delta[45:14], row_end[52:46], col_end[59:53], zero pad[63:60]
    input  logic [63:0]          s_axis_tdata,
    // cmd[0]
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // sum[63:0]
    output logic [SUM_W-1:0]     m_axis_tdata,
    // status[0]
    output logic                 m_axis_tuser
);

    localparam int RAW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CAW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RAW + CAW;
    localparam int DEPTH = MAX_ROWS * (2 ** CAW);
    localparam int ROW_CAP = (MAX_ROWS > IDX_MAX) ? IDX_MAX : MAX_ROWS;
    localparam int COL_CAP = (MAX_COLS > IDX_MAX) ? IDX_MAX : MAX_COLS;

    logic [IDX_W-1:0]   r_rows_used;
    logic [IDX_W-1:0]   r_cols_used;
    logic [IDX_W-1:0]   eff_rows;
    logic [IDX_W-1:0]   eff_cols;

    logic [IDX_W-1:0]   in_row;
    logic [IDX_W-1:0]   in_col;
    logic [DELTA_W-1:0] in_delta;
    logic [IDX_W-1:0]   in_row_end;
    logic [IDX_W-1:0]   in_col_end;
    logic               bad_add;
    logic               bad_query;
    logic               bad;

    logic               r_cmd;
    logic [IDX_W-1:0]   r_r1;
    logic [IDX_W-1:0]   r_c1;
    logic [IDX_W-1:0]   r_r2;
    logic [IDX_W-1:0]   r_c2;
    logic [SUM_W-1:0]   r_delta;
    logic               r_flag;
    logic [1:0]         r_k;
    logic [WALK_W-1:0]  r_i;
    logic [WALK_W-1:0]  r_j;
    logic [SUM_W-1:0]   r_acc;
    logic [AW-1:0]      r_clr_addr;

    logic [WALK_W-1:0]  term_row;
    logic [WALK_W-1:0]  term_col;
    logic [WALK_W-1:0]  load_col;
    logic [WALK_W-1:0]  low_i;
    logic [WALK_W-1:0]  low_j;

    logic [SUM_W-1:0]   r_mem [DEPTH];
    logic [SUM_W-1:0]   r_rdata;
    logic [AW-1:0]      mem_addr;
    logic [SUM_W-1:0]   mem_wdata;
    logic               mem_we;

    logic               r_out_valid;
    logic [SUM_W-1:0]   r_out_sum;
    logic               r_out_status;

    logic               start;
    t_ctrl              ctrl;
    t_flags             flags;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used <= IDX_W'(64);
            r_cols_used <= IDX_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS_USED: r_rows_used <= i_cfg_data;
                REG_COLS_USED: r_cols_used <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_rows = (r_rows_used > IDX_W'(ROW_CAP)) ? IDX_W'(ROW_CAP) : r_rows_used;
    assign eff_cols = (r_cols_used > IDX_W'(COL_CAP)) ? IDX_W'(COL_CAP) : r_cols_used;

    assign in_row     = s_axis_tdata[6:0];
    assign in_col     = s_axis_tdata[13:7];
    assign in_delta   = s_axis_tdata[45:14];
    assign in_row_end = s_axis_tdata[52:46];
    assign in_col_end = s_axis_tdata[59:53];

    assign bad_add = (in_row == '0) || (in_row > eff_rows)
                  || (in_col == '0) || (in_col > eff_cols);
    assign bad_query = (in_row_end == '0) || (in_row_end > eff_rows)
                    || (in_col_end == '0) || (in_col_end > eff_cols);
    assign bad = bad_add || ((s_axis_tuser == CMD_QUERY) && bad_query);

    assign s_axis_tready = ctrl.idle;
    assign start         = s_axis_tvalid && s_axis_tready;

    // The four prefix terms: (row_end, col_end) +, (row-1, col_end) -,
    // (row_end, col-1) -, (row-1, col-1) +.
    assign term_row = r_k[0] ? {1'b0, r_r1 - IDX_W'(1)} : {1'b0, r_r2};
    assign term_col = r_k[1] ? {1'b0, r_c1 - IDX_W'(1)} : {1'b0, r_c2};
    assign load_col = (r_cmd == CMD_QUERY) ? term_col : {1'b0, r_c1};

    assign low_i = r_i & (~r_i + WALK_W'(1));
    assign low_j = r_j & (~r_j + WALK_W'(1));

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd   <= s_axis_tuser;
            r_r1    <= in_row;
            r_c1    <= in_col;
            r_r2    <= in_row_end;
            r_c2    <= in_col_end;
            r_delta <= {{(SUM_W - DELTA_W){in_delta[DELTA_W-1]}}, in_delta};
            r_flag  <= bad;
            r_k     <= 2'd0;
            r_acc   <= '0;
            r_i     <= {1'b0, in_row};
        end else begin
            case (ctrl.i_op)
                IDX_LOAD: r_i <= term_row;
                IDX_UP:   r_i <= r_i + low_i;
                IDX_DOWN: r_i <= r_i - low_i;
                default:  ;
            endcase
            if (ctrl.k_inc) begin
                r_k <= r_k + 2'd1;
            end
            if (ctrl.acc_en) begin
                r_acc <= (r_k[0] ^ r_k[1]) ? r_acc - r_rdata : r_acc + r_rdata;
            end
        end
        case (ctrl.j_op)
            IDX_LOAD: r_j <= load_col;
            IDX_UP:   r_j <= r_j + low_j;
            IDX_DOWN: r_j <= r_j - low_j;
            default:  ;
        endcase
    end

    // Node memory, one port shared by the clearing pass, reads and writes.
    assign mem_we    = ctrl.mem_wr || ctrl.mem_clr;
    assign mem_wdata = ctrl.mem_clr ? '0 : r_rdata + r_delta;
    assign mem_addr  = ctrl.mem_clr ? r_clr_addr
                                    : {RAW'(r_i - WALK_W'(1)), CAW'(r_j - WALK_W'(1))};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (ctrl.mem_rd) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (ctrl.mem_clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit && flags.out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit && flags.out_free) begin
            r_out_sum    <= r_acc;
            r_out_status <= r_flag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sum;
    assign m_axis_tuser  = r_out_status;

    always_comb begin
        flags.start      = start;
        flags.start_step = bad ? S_OUT : ((s_axis_tuser == CMD_QUERY) ? S_Q_TERM : S_ADD_ROW);
        flags.i_end      = (r_i == '0) || (r_i > {1'b0, eff_rows});
        flags.j_end      = (r_j == '0) || (r_j > {1'b0, eff_cols});
        flags.k_more     = (r_k != 2'd3);
        flags.clr_more   = (r_clr_addr != AW'(DEPTH - 1));
        flags.out_free   = !r_out_valid || m_axis_tready;
    end

    fw2d_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

endmodule

/* src/fw2d_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module fw2d_seq
    import fw2d_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    t_step r_step;
    t_step n_step;
    t_ctrl cw;

    assign cw     = ctrl_rom(r_step);
    assign o_ctrl = cw;

    always_comb begin
        case (cw.cond)
            COND_NEXT:     n_step = r_step + t_step'(1);
            COND_JUMP:     n_step = cw.target;
            COND_START:    n_step = i_flags.start ? i_flags.start_step : r_step;
            COND_EMIT:     n_step = i_flags.out_free ? cw.target : r_step;
            COND_I_END:    n_step = i_flags.i_end ? cw.target : r_step + t_step'(1);
            COND_J_END:    n_step = i_flags.j_end ? cw.target : r_step + t_step'(1);
            COND_K_MORE:   n_step = i_flags.k_more ? cw.target : r_step + t_step'(1);
            COND_CLR_MORE: n_step = i_flags.clr_more ? cw.target : r_step + t_step'(1);
            default:       n_step = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLR;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
